### rtl/core/ssm_pkg.sv
// ssm_pkg: shared types, constants and helpers for the substring search matcher
// no dependencies; imported by every module of the block
package ssm_pkg;

    // pattern and field sizes
    localparam int PATTERN_MAX = 9;
    localparam int CHAR_W      = 21;
    localparam int POS_W       = 32;
    localparam int LEN_W       = 4;
    localparam int CHARS_PER_REG = 3;
    localparam int CFG_DATA_W  = CHARS_PER_REG * CHAR_W;
    localparam int CFG_IDX_W   = 3;

    // classified item queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_0_2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_3_5  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_6_8  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FUZZY    = 3'd4;

    // character codes used by fuzzy compare
    localparam logic [CHAR_W-1:0] CH_SPACE   = 21'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 21'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 21'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 21'h5A;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 21'h20;

    typedef struct packed {
        logic [CHAR_W-1:0] code_point;
        logic [POS_W-1:0]  position;
        logic              is_last;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  new_point;
    } t_out_item;

    // one classified character, front to back
    typedef struct packed {
        logic [PATTERN_MAX-1:0] match;      // pattern char i matches this char
        logic [PATTERN_MAX-1:0] ext;        // pattern char i is whitespace extending a run
        logic [PATTERN_MAX-1:0] final_sel;  // one-hot (all zero for length 0): last pattern char in use
        logic [POS_W-1:0]       position;
        logic                   is_last;
    } t_class_item;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c + CASE_DELTA) : c;
    endfunction

    function automatic logic chars_match(input logic [CHAR_W-1:0] p,
                                         input logic [CHAR_W-1:0] c,
                                         input logic fuzzy);
        logic r;
        if (!fuzzy) begin
            r = (p == c);
        end else if (is_ws(p)) begin
            r = is_ws(c);
        end else begin
            r = (fold(p) == fold(c));
        end
        return r;
    endfunction

endpackage

### rtl/core/ssm_front.sv
// ssm_front: configuration registers and per-character classification
// depends on ssm_pkg; feeds ssm_queue
module ssm_front
    import ssm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output t_class_item           o_push_item
);

    logic [CHAR_W-1:0] r_pat [PATTERN_MAX];
    logic [LEN_W-1:0]  r_len;
    logic              r_fuzzy;
    logic [LEN_W-1:0]  len_eff;
    logic              cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_pat[i] <= '0;
            end
            r_len   <= '0;
            r_fuzzy <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_PAT_0_2, REG_PAT_3_5, REG_PAT_6_8: begin
                    for (int i = 0; i < PATTERN_MAX; i++) begin
                        if (i / CHARS_PER_REG == int'(i_cfg_index)) begin
                            r_pat[i] <= i_cfg_data[(i % CHARS_PER_REG) * CHAR_W +: CHAR_W];
                        end
                    end
                end
                REG_PAT_LEN: begin
                    r_len <= i_cfg_data[LEN_W-1:0];
                end
                REG_FUZZY: begin
                    r_fuzzy <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // lengths beyond the pattern store use all of it
    assign len_eff = (r_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_len;

    // accept while the queue has room
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !o_in_stall;

    // compare the character against every pattern slot at once
    always_comb begin
        o_push_item.position = i_in_item.position;
        o_push_item.is_last  = i_in_item.is_last;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            o_push_item.match[i] = (LEN_W'(i) < len_eff)
                && chars_match(r_pat[i], i_in_item.code_point, r_fuzzy);
            o_push_item.ext[i] = (LEN_W'(i) < len_eff) && r_fuzzy
                && is_ws(r_pat[i]) && is_ws(i_in_item.code_point);
            o_push_item.final_sel[i] = (len_eff == LEN_W'(i + 1));
        end
    end

endmodule

### rtl/core/ssm_queue.sv
// ssm_queue: short first-in first-out queue of classified characters
// depends on ssm_pkg; sits between ssm_front and ssm_back
module ssm_queue
    import ssm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_class_item i_push_item,
    input  logic        i_pop,
    output t_class_item o_head,
    output t_q_status   o_status
);

    t_class_item       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // pointers and fill count
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

### rtl/core/ssm_back.sv
// ssm_back: prefix vector update, match detection and result register
// depends on ssm_pkg; drains ssm_queue
module ssm_back
    import ssm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_class_item i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    logic [PATTERN_MAX-1:0] r_active;
    logic                   r_found;
    logic                   r_out_valid;
    t_out_item              r_out_item;
    logic [PATTERN_MAX-1:0] n_active;
    logic                   n_found;
    logic [PATTERN_MAX-1:0] step_vec;
    logic                   hit;
    logic                   emit;
    t_out_item              emit_item;

    // take the next item whenever the result slot is free or being freed
    assign o_pop = !i_q_status.empty && (!r_out_valid || !i_out_stall);

    // one step of the prefix vector
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            step_vec[i] = (((i == 0) ? 1'b1 : r_active[(i == 0) ? 0 : i - 1])
                && i_head.match[i]) || (r_active[i] && i_head.ext[i]);
        end
    end

    assign hit = |(step_vec & i_head.final_sel);

    // search state and result decision
    always_comb begin
        n_active  = r_active;
        n_found   = r_found;
        emit      = 1'b0;
        emit_item = '0;
        if (r_found) begin
            if (i_head.is_last) begin
                n_active = '0;
                n_found  = 1'b0;
            end
        end else begin
            n_active = step_vec;
            if (hit) begin
                emit                = 1'b1;
                emit_item.found     = 1'b1;
                emit_item.new_point = i_head.position + POS_W'(1);
                n_found             = !i_head.is_last;
                if (i_head.is_last) begin
                    n_active = '0;
                end
            end else if (i_head.is_last) begin
                emit     = 1'b1;
                n_active = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= n_active;
                r_found  <= n_found;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_item <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/core/substring_search_matcher.sv
// substring_search_matcher: top level of the streaming substring matcher
// depends on ssm_pkg, ssm_front, ssm_queue, ssm_back
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-------------------------------
//   in       | input     | i_in_valid / o_in_stall  | i_in_item (char, position, last)
//   out      | output    | o_out_valid / i_out_stall| o_out_item (found, new_point)
//   cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// one character accepted per cycle while the queue is not full; the front classifies
// it in the cycle it is taken, a four-item queue decouples it from the back, which
// updates the prefix vector and loads the result register from the queue head
// reset is synchronous, active low, and clears configuration and search state
// a stalled output lets the queue fill; the input stalls only when it is full
module substring_search_matcher
    import ssm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic        push;
    t_class_item push_item;
    logic        pop;
    t_class_item head;
    t_q_status   q_status;

    // classification front end
    ssm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_item (push_item)
    );

    // decoupling queue
    ssm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    // match back end
    ssm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### rtl/core/ssm_checker.sv
// ssm_checker: port-level assertions for substring_search_matcher
// depends on ssm_pkg; bound to the top level below
module ssm_checker
    import ssm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_item              i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_item,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_item)))
        else $error("stalled input item changed");

    // a not-found result carries a zero point
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.new_point == '0))
        else $error("not-found result with nonzero point");

    // register writes carry known index and data
    a_cfg_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !$isunknown({i_cfg_index, i_cfg_data}))
        else $error("register write with unknown index or data");

    // queue is empty right after reset, so input is open and no result is valid
    a_open_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!o_in_stall && !o_out_valid))
        else $error("block not idle after reset");

endmodule

bind substring_search_matcher ssm_checker u_ssm_checker (.*);
